### sv/sioc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_pkg
// Shared types, register codes and reset values of the super I/O
// configuration port.
// ----------------------------------------------------------------------------
package sioc_pkg;

  // Sizes
  localparam int NUM_DEVICES     = 8;
  localparam int NUM_CONFIG_REGS = 256;
  localparam int DEV_AW          = $clog2(NUM_DEVICES);
  localparam int CFG_AW          = $clog2(NUM_CONFIG_REGS);
  localparam int OUT_DEPTH       = 3;
  localparam int OUT_PW          = $clog2(OUT_DEPTH);

  // Unlock / lock keys, control register and its pnp enable bit
  localparam logic [7:0] KEY_UNLOCK = 8'hAA;
  localparam logic [7:0] KEY_LOCK   = 8'h55;
  localparam logic [7:0] REG_PNPCTL = 8'hC1;
  localparam int         PNP_EN_BIT = 7;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [15:0] FDC_BASE  = 16'h03F0;

  // Bus port selectors
  localparam logic [2:0] PORT_INDEX    = 3'd0;
  localparam logic [2:0] PORT_DATA     = 3'd1;
  localparam logic [2:0] PORT_PNP_IDX  = 3'd2;
  localparam logic [2:0] PORT_PNP_DATA = 3'd3;
  localparam logic [2:0] PORT_PNP_RD   = 3'd4;

  // Plug-and-play register indexes
  localparam logic [7:0] PR_DEVICE = 8'h07;
  localparam logic [7:0] PR_ENABLE = 8'h30;
  localparam logic [7:0] PR_BASEHI = 8'h60;
  localparam logic [7:0] PR_BASELO = 8'h61;
  localparam logic [7:0] PR_IRQ    = 8'h70;
  localparam logic [7:0] PR_DMA    = 8'h74;

  // Request and response beats
  typedef struct packed {
    logic       func;
    logic [2:0] port_sel;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        pnp_on;
    logic        event_valid;
    logic [1:0]  event_device;
    logic        event_enabled;
    logic [15:0] event_base;
    logic [7:0]  event_irq;
  } rsp_t;

  // One logical device's register set
  typedef struct packed {
    logic [7:0]  enable;
    logic [15:0] base;
    logic [7:0]  irq;
    logic [7:0]  dma;
  } dev_word_t;

  // Work left for the memory stage
  typedef enum logic [2:0] {
    OP_IMM,
    OP_RD_CFG,
    OP_WR_CFG,
    OP_RD_DEV,
    OP_WR_DEV
  } op_t;

  // Register set of a device after reset
  function automatic dev_word_t dev_reset(input logic [DEV_AW-1:0] idx);
    dev_word_t w;
    w = '0;
    if (idx == DEV_AW'(0)) begin
      w.enable = 8'd1; w.base = 16'h03F0; w.irq = 8'd6; w.dma = 8'd2;
    end else if (idx == DEV_AW'(1)) begin
      w.enable = 8'd1; w.base = 16'h03F8; w.irq = 8'd4;
    end else if (idx == DEV_AW'(2)) begin
      w.enable = 8'd1; w.base = 16'h02F8; w.irq = 8'd3;
    end else if (idx == DEV_AW'(3)) begin
      w.enable = 8'd1; w.base = 16'h0378; w.irq = 8'd7;
    end
    return w;
  endfunction

  // Registers a device access may touch
  function automatic logic dev_reg_known(input logic [7:0] idx);
    return (idx == PR_ENABLE) || (idx == PR_BASEHI) || (idx == PR_BASELO) ||
           (idx == PR_IRQ) || (idx == PR_DMA);
  endfunction

endpackage

### sv/sioc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sioc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/super_io_config_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// super_io_config_registers
// Configuration port front end: lock/unlock key, 256-byte register file and
// plug-and-play logical device registers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one bus access per beat (read or write, port, byte). Every
//   access yields exactly one rsp beat with the read byte, the current pnp
//   enable and an optional device setup event.
//   rsp_valid rises once the beat has left the memory stage; with no stall
//   that rsp beat is taken on the next edge. One access per cycle is
//   sustained while rsp is not stalled; the register file and device RAMs
//   are read at accept and written back by the memory stage with forwarding.
//   Scalar state (lock, indexes, selected device) updates at accept.
//   Responses queue in a three-entry buffer; req_stall rises only when that
//   buffer and the memory stage together hold three beats, so a stalled
//   receiver holds rsp steady while at most two more beats are taken behind
//   it, and req_stall then stays high until a beat pops.
//   Reset (rst, synchronous) locks the port, clears indexes and marks every
//   register file byte and device set as holding its reset value through
//   per-entry valid bits; no clearing pass is needed and req is taken in
//   the first cycle after reset.
// ----------------------------------------------------------------------------
module super_io_config_registers (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sioc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sioc_pkg::rsp_t  rsp
);

  // Scalar state
  logic       locked, locked_next;
  logic       pnp_en, pnp_en_next;
  logic [7:0] config_index, config_index_next;
  logic [7:0] pnp_index, pnp_index_next;
  logic [2:0] current_device, current_device_next;

  // Valid bits over the memories
  logic [sioc_pkg::NUM_CONFIG_REGS-1:0] cfg_vld;
  logic [sioc_pkg::NUM_DEVICES-1:0]     dev_vld;

  // Memory stage
  logic                       s1_v;
  sioc_pkg::op_t              s1_op;
  logic [7:0]                 s1_imm;
  logic [7:0]                 s1_wdata;
  logic [7:0]                 s1_reg;
  logic [2:0]                 s1_dev;
  logic                       s1_pnp_on;
  logic [sioc_pkg::CFG_AW-1:0] s1_cfg_addr;
  logic [sioc_pkg::DEV_AW-1:0] s1_dev_addr;
  logic                       s1_cfg_vld;
  logic                       s1_dev_vld;

  // Last write of each memory, for forwarding
  logic                        fw_cfg_en;
  logic [sioc_pkg::CFG_AW-1:0] fw_cfg_addr;
  logic [7:0]                  fw_cfg_data;
  logic                        fw_dev_en;
  logic [sioc_pkg::DEV_AW-1:0] fw_dev_addr;
  sioc_pkg::dev_word_t         fw_dev_data;

  // Response buffer
  sioc_pkg::rsp_t            obuf [sioc_pkg::OUT_DEPTH];
  logic [sioc_pkg::OUT_PW-1:0] wr_ptr, rd_ptr;
  logic [sioc_pkg::OUT_PW:0]   cnt;

  logic                        accept, pop;
  sioc_pkg::op_t               op;
  logic [7:0]                  imm;
  logic                        dev_in_range;
  logic [sioc_pkg::DEV_AW-1:0] dev_addr;
  logic [sioc_pkg::CFG_AW-1:0] cfg_addr;

  logic [7:0]                  cfg_rdata, cfg_old;
  logic [$bits(sioc_pkg::dev_word_t)-1:0] dev_rdata;
  sioc_pkg::dev_word_t         dev_old, dev_new;
  logic                        cfg_we, dev_we;
  sioc_pkg::rsp_t              s1_rsp;

  // Handshake
  assign accept    = req_valid && !req_stall;
  assign pop       = rsp_valid && !rsp_stall;
  assign req_stall = ({1'b0, cnt} + {{sioc_pkg::OUT_PW{1'b0}}, 1'b0, s1_v}) >=
                     (sioc_pkg::OUT_PW + 2)'(sioc_pkg::OUT_DEPTH);

  // Device selection and memory read addresses
  assign dev_in_range = {1'b0, current_device} < 4'(sioc_pkg::NUM_DEVICES);
  assign dev_addr     = dev_in_range ? current_device[sioc_pkg::DEV_AW-1:0] : '0;
  assign cfg_addr     = config_index[sioc_pkg::CFG_AW-1:0];

  // Access decode and scalar state update
  always_comb begin
    locked_next         = locked;
    pnp_en_next         = pnp_en;
    config_index_next   = config_index;
    pnp_index_next      = pnp_index;
    current_device_next = current_device;
    op                  = sioc_pkg::OP_IMM;
    imm                 = sioc_pkg::BYTE_IDLE;
    if (req.func) begin
      unique case (req.port_sel)
        sioc_pkg::PORT_INDEX: begin
          if (locked) begin
            if (req.write_data == sioc_pkg::KEY_UNLOCK) locked_next = 1'b0;
          end else if (req.write_data == sioc_pkg::KEY_LOCK) begin
            locked_next = 1'b1;
          end else begin
            config_index_next = req.write_data;
          end
        end
        sioc_pkg::PORT_DATA: begin
          if (!locked) begin
            op = sioc_pkg::OP_WR_CFG;
            if (config_index == sioc_pkg::REG_PNPCTL) begin
              pnp_en_next = req.write_data[sioc_pkg::PNP_EN_BIT];
            end
          end
        end
        sioc_pkg::PORT_PNP_IDX: begin
          if (pnp_en) pnp_index_next = req.write_data;
        end
        sioc_pkg::PORT_PNP_DATA: begin
          if (pnp_en) begin
            if (pnp_index == sioc_pkg::PR_DEVICE) begin
              current_device_next = req.write_data[2:0];
            end else if (dev_in_range && sioc_pkg::dev_reg_known(pnp_index)) begin
              op = sioc_pkg::OP_WR_DEV;
            end
          end
        end
        default: ;
      endcase
    end else begin
      unique case (req.port_sel)
        sioc_pkg::PORT_INDEX: begin
          if (!locked) imm = config_index;
        end
        sioc_pkg::PORT_DATA: begin
          if (!locked) op = sioc_pkg::OP_RD_CFG;
        end
        sioc_pkg::PORT_PNP_RD: begin
          if (pnp_en) begin
            if (pnp_index == sioc_pkg::PR_DEVICE) begin
              imm = {5'd0, current_device};
            end else if (dev_in_range && sioc_pkg::dev_reg_known(pnp_index)) begin
              op = sioc_pkg::OP_RD_DEV;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Memories
  sioc_ram #(
    .WIDTH (8),
    .DEPTH (sioc_pkg::NUM_CONFIG_REGS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (s1_cfg_addr),
    .wdata (s1_wdata),
    .re    (accept),
    .raddr (cfg_addr),
    .rdata (cfg_rdata)
  );

  sioc_ram #(
    .WIDTH ($bits(sioc_pkg::dev_word_t)),
    .DEPTH (sioc_pkg::NUM_DEVICES)
  ) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (s1_dev_addr),
    .wdata (dev_new),
    .re    (accept),
    .raddr (dev_addr),
    .rdata (dev_rdata)
  );

  // Old contents, with forwarding of the write made alongside the read
  always_comb begin
    if (fw_cfg_en && fw_cfg_addr == s1_cfg_addr) cfg_old = fw_cfg_data;
    else if (s1_cfg_vld)                         cfg_old = cfg_rdata;
    else                                         cfg_old = 8'd0;

    if (fw_dev_en && fw_dev_addr == s1_dev_addr) dev_old = fw_dev_data;
    else if (s1_dev_vld)                         dev_old = sioc_pkg::dev_word_t'(dev_rdata);
    else                                         dev_old = sioc_pkg::dev_reset(s1_dev_addr);
  end

  // Modify and build the response
  always_comb begin
    dev_new = dev_old;
    s1_rsp  = '0;
    s1_rsp.read_data = s1_imm;
    s1_rsp.pnp_on    = s1_pnp_on;
    cfg_we  = s1_v && (s1_op == sioc_pkg::OP_WR_CFG);
    dev_we  = s1_v && (s1_op == sioc_pkg::OP_WR_DEV);
    unique case (s1_op)
      sioc_pkg::OP_RD_CFG: s1_rsp.read_data = cfg_old;
      sioc_pkg::OP_RD_DEV: begin
        priority if (s1_reg == sioc_pkg::PR_ENABLE) s1_rsp.read_data = dev_old.enable;
        else if (s1_reg == sioc_pkg::PR_BASELO) s1_rsp.read_data = dev_old.base[7:0];
        else if (s1_reg == sioc_pkg::PR_BASEHI) s1_rsp.read_data = dev_old.base[15:8];
        else if (s1_reg == sioc_pkg::PR_IRQ)    s1_rsp.read_data = dev_old.irq;
        else                                    s1_rsp.read_data = dev_old.dma;
      end
      sioc_pkg::OP_WR_DEV: begin
        priority if (s1_reg == sioc_pkg::PR_ENABLE) begin
          dev_new.enable = s1_wdata;
          if (dev_old.enable != s1_wdata && s1_dev[2] == 1'b0) begin
            s1_rsp.event_valid   = 1'b1;
            s1_rsp.event_device  = s1_dev[1:0];
            s1_rsp.event_enabled = s1_wdata[0];
            s1_rsp.event_base    = (s1_dev == 3'd0) ? sioc_pkg::FDC_BASE : dev_old.base;
            s1_rsp.event_irq     = dev_old.irq;
          end
        end
        else if (s1_reg == sioc_pkg::PR_BASELO) dev_new.base[7:0]  = s1_wdata;
        else if (s1_reg == sioc_pkg::PR_BASEHI) dev_new.base[15:8] = s1_wdata;
        else if (s1_reg == sioc_pkg::PR_IRQ)    dev_new.irq        = s1_wdata;
        else                                    dev_new.dma        = s1_wdata;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      locked         <= 1'b1;
      pnp_en         <= 1'b0;
      config_index   <= '0;
      pnp_index      <= '0;
      current_device <= '0;
      cfg_vld        <= '0;
      dev_vld        <= '0;
      s1_v           <= 1'b0;
      fw_cfg_en      <= 1'b0;
      fw_dev_en      <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      cnt            <= '0;
    end else begin
      s1_v <= accept;
      if (accept) begin
        locked         <= locked_next;
        pnp_en         <= pnp_en_next;
        config_index   <= config_index_next;
        pnp_index      <= pnp_index_next;
        current_device <= current_device_next;
      end
      if (cfg_we) begin
        cfg_vld[s1_cfg_addr] <= 1'b1;
        fw_cfg_en            <= 1'b1;
      end
      if (dev_we) begin
        dev_vld[s1_dev_addr] <= 1'b1;
        fw_dev_en            <= 1'b1;
      end
      if (s1_v) begin
        wr_ptr <= (wr_ptr == sioc_pkg::OUT_PW'(sioc_pkg::OUT_DEPTH - 1)) ? '0 :
                  wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sioc_pkg::OUT_PW'(sioc_pkg::OUT_DEPTH - 1)) ? '0 :
                  rd_ptr + 1'b1;
      end
      cnt <= cnt + {{sioc_pkg::OUT_PW{1'b0}}, s1_v} - {{sioc_pkg::OUT_PW{1'b0}}, pop};
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op;
      s1_imm      <= imm;
      s1_wdata    <= req.write_data;
      s1_reg      <= pnp_index;
      s1_dev      <= current_device;
      s1_pnp_on   <= pnp_en_next;
      s1_cfg_addr <= cfg_addr;
      s1_dev_addr <= dev_addr;
      s1_cfg_vld  <= cfg_vld[cfg_addr];
      s1_dev_vld  <= dev_vld[dev_addr];
    end
    if (cfg_we) begin
      fw_cfg_addr <= s1_cfg_addr;
      fw_cfg_data <= s1_wdata;
    end
    if (dev_we) begin
      fw_dev_addr <= s1_dev_addr;
      fw_dev_data <= dev_new;
    end
    if (s1_v) begin
      obuf[wr_ptr] <= s1_rsp;
    end
  end

  assign rsp_valid = (cnt != '0);
  assign rsp       = obuf[rd_ptr];

endmodule

### sv/sioc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioc_checker
// Port-level checks of the configuration port, bound to the top level.
// ----------------------------------------------------------------------------
module sioc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input sioc_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input sioc_pkg::rsp_t rsp
);

  // Stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  // Nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  // Event fields are zero without an event
  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.event_valid |-> rsp.event_device == 2'd0 &&
      !rsp.event_enabled && rsp.event_base == 16'd0 && rsp.event_irq == 8'd0)
    else $error("event fields set without event");

  // Events come from writes, and the floppy base is fixed
  a_event_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.event_valid |-> rsp.read_data == sioc_pkg::BYTE_IDLE &&
      rsp.pnp_on && (rsp.event_device != 2'd0 || rsp.event_base == sioc_pkg::FDC_BASE))
    else $error("malformed setup event");

endmodule

bind super_io_config_registers sioc_checker u_sioc_checker (.*);

### bench/super_io_config_registers_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// super_io_config_registers_tb
// Self-checking bench for the super I/O configuration port. A directed table
// walks the lock key, the register file, the pnp enable bit and the device
// registers. Random accesses follow, built mostly from well-formed unlock,
// index/data and device-select sequences. Every response beat is compared,
// field by field, with its table entry or with an in-bench model of the port.
// This runs under four mixes of request gaps and response stalls.
// ----------------------------------------------------------------------------
module super_io_config_registers_tb;
  import sioc_pkg::*;

  localparam logic       FUNC_RD          = 1'b0;
  localparam logic       FUNC_WR          = 1'b1;
  localparam logic [2:0] PORT_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] PORT_UNMAPPED_HI = 3'd7;
  localparam int         LAST_EVENT_DEV   = 3;
  localparam int         RAND_PER_PHASE   = 385;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         CYCLE_LIMIT      = 200000;

  typedef struct packed {
    req_t beat;
    logic typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Model of the port state
  logic       is_locked;
  logic       pnp_enabled;
  logic [7:0] cfg_idx;
  logic [7:0] pnp_reg;
  logic [2:0] sel_dev;
  logic [7:0] cfg_mem [NUM_CONFIG_REGS];
  logic [7:0] dev_en [NUM_DEVICES];
  logic [15:0] dev_base [NUM_DEVICES];
  logic [7:0] dev_irq [NUM_DEVICES];
  logic [7:0] dev_dma [NUM_DEVICES];

  rsp_t     due_rsp[$];
  dir_row_t directed_q[$];
  rsp_t     oldest;

  int src_idle_pct;
  int sink_stall_pct;
  int accepted_n;
  int dir_n;
  int rsp_n;
  int event_n;
  int mismatch_n;
  int cycle_n;

  super_io_config_registers u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic req_t mk_req(input logic f, input logic [2:0] p, input logic [7:0] d);
    req_t r;
    r.func       = f;
    r.port_sel   = p;
    r.write_data = d;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [7:0] rd, input logic on, input logic ev,
                                  input logic [1:0] dev, input logic en,
                                  input logic [15:0] base, input logic [7:0] irq);
    rsp_t r;
    r.read_data     = rd;
    r.pnp_on        = on;
    r.event_valid   = ev;
    r.event_device  = dev;
    r.event_enabled = en;
    r.event_base    = base;
    r.event_irq     = irq;
    return r;
  endfunction

  // Apply one access to the model; returns the response it should produce
  function automatic rsp_t predict_access(input req_t a);
    rsp_t       r;
    logic [7:0] v;
    logic [7:0] old_en;
    logic [2:0] d;
    r = '0;
    r.read_data = BYTE_IDLE;
    v = a.write_data;
    d = sel_dev;
    if (a.func == FUNC_WR) begin
      case (a.port_sel)
        PORT_INDEX: begin
          if (is_locked) begin
            if (v == KEY_UNLOCK) is_locked = 1'b0;
          end else if (v == KEY_LOCK) begin
            is_locked = 1'b1;
          end else begin
            cfg_idx = v;
          end
        end
        PORT_DATA: begin
          if (!is_locked) begin
            cfg_mem[cfg_idx] = v;
            if (cfg_idx == REG_PNPCTL) pnp_enabled = v[PNP_EN_BIT];
          end
        end
        PORT_PNP_IDX: begin
          if (pnp_enabled) pnp_reg = v;
        end
        PORT_PNP_DATA: begin
          if (pnp_enabled) begin
            if (pnp_reg == PR_DEVICE) begin
              sel_dev = v[2:0];
            end else if (int'(d) < NUM_DEVICES) begin
              case (pnp_reg)
                PR_ENABLE: begin
                  old_en = dev_en[d];
                  dev_en[d] = v;
                  // setup event only for the four legacy devices
                  if (old_en != v && int'(d) <= LAST_EVENT_DEV) begin
                    r.event_valid   = 1'b1;
                    r.event_device  = d[1:0];
                    r.event_enabled = v[0];
                    r.event_base    = (d == 3'd0) ? FDC_BASE : dev_base[d];
                    r.event_irq     = dev_irq[d];
                  end
                end
                PR_BASELO: dev_base[d][7:0]  = v;
                PR_BASEHI: dev_base[d][15:8] = v;
                PR_IRQ:    dev_irq[d] = v;
                PR_DMA:    dev_dma[d] = v;
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (a.port_sel)
        PORT_INDEX: if (!is_locked) r.read_data = cfg_idx;
        PORT_DATA:  if (!is_locked) r.read_data = cfg_mem[cfg_idx];
        PORT_PNP_RD: begin
          if (pnp_enabled) begin
            if (pnp_reg == PR_DEVICE) begin
              r.read_data = {5'd0, sel_dev};
            end else if (int'(d) < NUM_DEVICES) begin
              case (pnp_reg)
                PR_ENABLE: r.read_data = dev_en[d];
                PR_BASELO: r.read_data = dev_base[d][7:0];
                PR_BASEHI: r.read_data = dev_base[d][15:8];
                PR_IRQ:    r.read_data = dev_irq[d];
                PR_DMA:    r.read_data = dev_dma[d];
                default:   r.read_data = BYTE_IDLE;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    r.pnp_on = pnp_enabled;
    return r;
  endfunction

  // Present one request beat, wait for it to be taken, queue its response
  task automatic send_access(input req_t a, input logic typed, input rsp_t want);
    rsp_t model_rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    model_rsp = predict_access(a);
    due_rsp.push_back(typed ? want : model_rsp);
    accepted_n++;
  endtask

  task automatic add_row(input logic f, input logic [2:0] p, input logic [7:0] d,
                         input logic typed, input rsp_t want);
    dir_row_t row;
    row.beat  = mk_req(f, p, d);
    row.typed = typed;
    row.want  = want;
    directed_q.push_back(row);
  endtask

  function automatic logic [7:0] pick_pnp_reg();
    case ($urandom_range(7))
      0, 1:    return PR_ENABLE;
      2:       return PR_BASEHI;
      3:       return PR_BASELO;
      4:       return PR_IRQ;
      5:       return PR_DMA;
      6:       return PR_DEVICE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random traffic, grouped into short sequences that reach the deeper state
  task automatic run_random(input int n);
    req_t       burst[$];
    int         sent;
    int         kind;
    logic [7:0] idx;
    logic [7:0] d;
    logic [7:0] reg_sel;
    sent = 0;
    while (sent < n) begin
      burst.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
        // lock key traffic
        case ($urandom_range(2))
          0:       d = KEY_LOCK;
          1:       d = KEY_UNLOCK;
          default: d = 8'($urandom_range(255));
        endcase
        burst.push_back(mk_req(FUNC_WR, PORT_INDEX, d));
        burst.push_back(mk_req(FUNC_RD, PORT_INDEX, 8'($urandom_range(255))));
      end else if (kind < 25) begin
        // unlock, select a register, then touch it
        idx = ($urandom_range(3) == 0) ? REG_PNPCTL : 8'($urandom_range(255));
        burst.push_back(mk_req(FUNC_WR, PORT_INDEX, KEY_UNLOCK));
        burst.push_back(mk_req(FUNC_WR, PORT_INDEX, idx));
        repeat ($urandom_range(1, 3)) begin
          d = 8'($urandom_range(255));
          if (idx == REG_PNPCTL) d[PNP_EN_BIT] = ($urandom_range(9) < 8);
          case ($urandom_range(2))
            0:       burst.push_back(mk_req(FUNC_WR, PORT_DATA, d));
            1:       burst.push_back(mk_req(FUNC_RD, PORT_DATA, d));
            default: burst.push_back(mk_req(FUNC_RD, PORT_INDEX, d));
          endcase
        end
      end else if (kind < 35) begin
        // turn the pnp ports on (mostly)
        d = 8'($urandom_range(255));
        d[PNP_EN_BIT] = ($urandom_range(99) < 85);
        burst.push_back(mk_req(FUNC_WR, PORT_INDEX, KEY_UNLOCK));
        burst.push_back(mk_req(FUNC_WR, PORT_INDEX, REG_PNPCTL));
        burst.push_back(mk_req(FUNC_WR, PORT_DATA, d));
      end else if (kind < 85) begin
        // select a device, then read or write its registers
        d = 8'($urandom_range(255));
        if ($urandom_range(9) < 7) d[2] = 1'b0;
        burst.push_back(mk_req(FUNC_WR, PORT_PNP_IDX, PR_DEVICE));
        burst.push_back(mk_req(FUNC_WR, PORT_PNP_DATA, d));
        repeat ($urandom_range(1, 4)) begin
          reg_sel = pick_pnp_reg();
          burst.push_back(mk_req(FUNC_WR, PORT_PNP_IDX, reg_sel));
          if ($urandom_range(3) == 0) begin
            burst.push_back(mk_req(FUNC_RD, PORT_PNP_RD, 8'($urandom_range(255))));
          end else begin
            d = 8'($urandom_range(255));
            if (reg_sel == PR_ENABLE && $urandom_range(1) == 0) d = 8'($urandom_range(1));
            burst.push_back(mk_req(FUNC_WR, PORT_PNP_DATA, d));
            if ($urandom_range(2) == 0)
              burst.push_back(mk_req(FUNC_RD, PORT_PNP_RD, 8'($urandom_range(255))));
          end
        end
      end else begin
        // noise: any access on any port
        repeat ($urandom_range(1, 4))
          burst.push_back(mk_req(1'($urandom_range(1)), 3'($urandom_range(7)),
                                 8'($urandom_range(255))));
      end
      foreach (burst[i]) send_access(burst[i], 1'b0, '0);
      sent += burst.size();
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: rsp.%s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_n++;
    end
  endtask

  // Response receiver: random stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsp.size() == 0) begin
        $display("%0t ns: rsp beat with none expected, expected nothing, got 0x%0h",
                 $time, rsp);
        mismatch_n++;
      end else begin
        oldest = due_rsp.pop_front();
        rsp_n++;
        if (oldest.event_valid) event_n++;
        check_field("read_data",     oldest.read_data,     rsp.read_data);
        check_field("pnp_on",        oldest.pnp_on,        rsp.pnp_on);
        check_field("event_valid",   oldest.event_valid,   rsp.event_valid);
        check_field("event_device",  oldest.event_device,  rsp.event_device);
        check_field("event_enabled", oldest.event_enabled, rsp.event_enabled);
        check_field("event_base",    oldest.event_base,    rsp.event_base);
        check_field("event_irq",     oldest.event_irq,     rsp.event_irq);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still due", cycle_n, due_rsp.size());
      $display("super_io_config_registers verification failed");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    rsp_stall      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    accepted_n     = 0;
    rsp_n          = 0;
    event_n        = 0;
    mismatch_n     = 0;
    cycle_n        = 0;

    // Model state after reset
    is_locked   = 1'b1;
    pnp_enabled = 1'b0;
    cfg_idx     = '0;
    pnp_reg     = '0;
    sel_dev     = '0;
    foreach (cfg_mem[i]) cfg_mem[i] = '0;
    for (int i = 0; i < NUM_DEVICES; i++) begin
      dev_en[i]   = '0;
      dev_base[i] = '0;
      dev_irq[i]  = '0;
      dev_dma[i]  = '0;
    end
    for (int i = 0; i <= LAST_EVENT_DEV; i++) dev_en[i] = 8'd1;
    dev_base[0] = FDC_BASE;
    dev_base[1] = 16'h03F8;
    dev_base[2] = 16'h02F8;
    dev_base[3] = 16'h0378;
    dev_irq[0]  = 8'd6;
    dev_irq[1]  = 8'd4;
    dev_irq[2]  = 8'd3;
    dev_irq[3]  = 8'd7;
    dev_dma[0]  = 8'd2;

    // Directed table: locked port, pnp off, unlock, pnp on, device registers
    add_row(FUNC_RD, PORT_INDEX,       8'h00, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_RD, PORT_DATA,        8'hFF, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_DATA,        8'h5A, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_INDEX,       8'hFF, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_RD, PORT_PNP_RD,      8'h00, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_PNP_IDX,     PR_ENABLE, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_PNP_DATA,    8'h00, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_INDEX,       KEY_UNLOCK, 1'b1, mk_rsp(BYTE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_RD, PORT_INDEX,       8'h00, 1'b1, mk_rsp(8'h00, 0, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_INDEX,       REG_PNPCTL, 1'b0, '0);
    add_row(FUNC_WR, PORT_DATA,        8'hFF, 1'b1, mk_rsp(BYTE_IDLE, 1, 0, 0, 0, 0, 0));
    add_row(FUNC_RD, PORT_DATA,        8'h00, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_IDX,     PR_ENABLE, 1'b0, '0);
    add_row(FUNC_RD, PORT_PNP_RD,      8'h00, 1'b1, mk_rsp(8'h01, 1, 0, 0, 0, 0, 0));
    // floppy disabled: event carries the fixed base and its IRQ
    add_row(FUNC_WR, PORT_PNP_DATA,    8'h00, 1'b1, mk_rsp(BYTE_IDLE, 1, 1, 0, 0, FDC_BASE, 8'd6));
    add_row(FUNC_WR, PORT_PNP_DATA,    8'h00, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_IDX,     PR_DEVICE, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_DATA,    8'hFD, 1'b0, '0);
    add_row(FUNC_RD, PORT_PNP_RD,      8'h00, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_IDX,     PR_ENABLE, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_DATA,    8'hFF, 1'b0, '0);
    add_row(FUNC_WR, PORT_PNP_IDX,     8'h00, 1'b0, '0);
    add_row(FUNC_RD, PORT_PNP_RD,      8'h00, 1'b1, mk_rsp(BYTE_IDLE, 1, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_INDEX,       KEY_LOCK, 1'b0, '0);
    add_row(FUNC_RD, PORT_PNP_IDX,     8'h00, 1'b1, mk_rsp(BYTE_IDLE, 1, 0, 0, 0, 0, 0));
    add_row(FUNC_WR, PORT_PNP_RD,      8'h12, 1'b0, '0);
    add_row(FUNC_RD, PORT_UNMAPPED_HI, 8'h00, 1'b0, '0);
    add_row(FUNC_WR, PORT_UNMAPPED_LO, 8'hFF, 1'b0, '0);
    dir_n = directed_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Idle mixes: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct <= 70; end
        default: begin src_idle_pct = 38; sink_stall_pct <= 38; end
      endcase
      if (ph == 0) begin
        foreach (directed_q[i])
          send_access(directed_q[i].beat, directed_q[i].typed, directed_q[i].want);
      end
      run_random(RAND_PER_PHASE);
    end
    req_valid <= 1'b0;

    while (due_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d accesses (%0d from the directed table) across four gap/stall mixes.",
             accepted_n, dir_n);
    $display("Responses checked: %0d, device setup events: %0d, mismatches: %0d",
             rsp_n, event_n, mismatch_n);
    if (mismatch_n == 0) begin
      $display("super_io_config_registers verification clean");
    end else begin
      $display("super_io_config_registers verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/sioc_pkg.sv
sv/sioc_ram.sv
sv/super_io_config_registers.sv
sv/sioc_checker.sv
bench/super_io_config_registers_tb.sv
